### hw/rtl/stop_and_wait_ack_receiver_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stop-and-wait acknowledgment receiver
// Concurrent checks that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef STOP_AND_WAIT_ACK_RECEIVER_MACROS_SVH
`define STOP_AND_WAIT_ACK_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define SWAR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swar check failed");

// Next-cycle implication
`define SWAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swar check failed");

`else

`define SWAR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SWAR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/swar_pkg.sv
// ----------------------------------------------------------------------------
// swar_pkg
// Types and constants shared by the stop-and-wait acknowledgment receiver.
// ----------------------------------------------------------------------------
package swar_pkg;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_FLAG    = 2'd0;
    localparam logic [1:0] REG_ADDRESS = 2'd1;
    localparam logic [1:0] REG_LIMIT   = 2'd2;

    localparam logic [7:0] FLAG_RESET    = 8'h7E;
    localparam logic [7:0] ADDRESS_RESET = 8'h03;
    localparam logic [7:0] LIMIT_RESET   = 8'd3;

    // supervisory control codes
    localparam logic [7:0] RR_BASE  = 8'h05;
    localparam logic [7:0] REJ_BASE = 8'h01;

    typedef enum logic [1:0] {
        CMD_BYTE   = 2'd0,
        CMD_EXPIRY = 2'd1,
        CMD_START  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_SEND = 2'd1,
        ACT_ACK  = 2'd2,
        ACT_FAIL = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        PS_START = 3'd0,
        PS_FLAG  = 3'd1,
        PS_ADDR  = 3'd2,
        PS_CTRL  = 3'd3,
        PS_BCC   = 3'd4
    } parse_state_t;

    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] address_byte;
        logic [7:0] timeout_limit;
    } cfg_t;

    typedef struct packed {
        action_t action;
        logic    seq_bit;
    } result_t;

    function automatic logic [7:0] rr_code(input logic n);
        rr_code = RR_BASE | {n, 7'd0};
    endfunction

    function automatic logic [7:0] rej_code(input logic n);
        rej_code = REJ_BASE | {n, 7'd0};
    endfunction

endpackage

### hw/rtl/swar_cfg.sv
// ----------------------------------------------------------------------------
// swar_cfg
// APB register file: flag byte, address byte and timeout limit.
// ----------------------------------------------------------------------------
module swar_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swar_pkg::ADDR_W-1:0] paddr,
    input  logic [swar_pkg::DATA_W-1:0] pwdata,
    output logic [swar_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output swar_pkg::cfg_t              cfg
);

    swar_pkg::cfg_t cfg_reg;
    swar_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                swar_pkg::REG_FLAG:    cfg_next.flag_byte     = pwdata[7:0];
                swar_pkg::REG_ADDRESS: cfg_next.address_byte  = pwdata[7:0];
                swar_pkg::REG_LIMIT:   cfg_next.timeout_limit = pwdata[7:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_byte     <= swar_pkg::FLAG_RESET;
            cfg_reg.address_byte  <= swar_pkg::ADDRESS_RESET;
            cfg_reg.timeout_limit <= swar_pkg::LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            swar_pkg::REG_FLAG:    prdata = {24'd0, cfg_reg.flag_byte};
            swar_pkg::REG_ADDRESS: prdata = {24'd0, cfg_reg.address_byte};
            swar_pkg::REG_LIMIT:   prdata = {24'd0, cfg_reg.timeout_limit};
            default:               prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/swar_core.sv
// ----------------------------------------------------------------------------
// swar_core
// Frame parser, sequence bit, expiry counter and armed flag; one item per fire.
// ----------------------------------------------------------------------------
`include "stop_and_wait_ack_receiver_macros.svh"

module swar_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [1:0]          cmd,
    input  logic [7:0]          rx_byte,
    input  swar_pkg::cfg_t      cfg,
    output swar_pkg::result_t   result
);

    swar_pkg::parse_state_t ps_reg;
    swar_pkg::parse_state_t ps_next;
    logic [7:0]             ctrl_reg;
    logic [7:0]             ctrl_next;
    logic                   seq_reg;
    logic                   seq_next;
    logic [8:0]             cnt_reg;
    logic [8:0]             cnt_next;
    logic                   active_reg;
    logic                   active_next;
    swar_pkg::action_t      act;
    logic [8:0]             cnt_inc;
    logic                   frame_done;
    logic                   is_ctrl;

    assign cnt_inc = cnt_reg + 9'd1;
    assign is_ctrl = (rx_byte == swar_pkg::rr_code(1'b0)) || (rx_byte == swar_pkg::rr_code(1'b1))
                  || (rx_byte == swar_pkg::rej_code(1'b0))
                  || (rx_byte == swar_pkg::rej_code(1'b1));

    always_comb
    begin
        ps_next     = ps_reg;
        ctrl_next   = ctrl_reg;
        seq_next    = seq_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        act         = swar_pkg::ACT_NONE;
        frame_done  = 1'b0;

        case (cmd)
            swar_pkg::CMD_START:
            begin
                active_next = 1'b1;
                cnt_next    = '0;
                ps_next     = swar_pkg::PS_START;
                act         = swar_pkg::ACT_SEND;
            end
            swar_pkg::CMD_EXPIRY:
            begin
                if (active_reg)
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc > {1'b0, cfg.timeout_limit})
                    begin
                        active_next = 1'b0;
                        ps_next     = swar_pkg::PS_START;
                        act         = swar_pkg::ACT_FAIL;
                    end
                    else
                    begin
                        act = swar_pkg::ACT_SEND;
                    end
                end
            end
            swar_pkg::CMD_BYTE:
            begin
                if (active_reg)
                begin
                    // address wins over flag after a flag; flag wins over control after
                    // an address and over BCC after a control byte
                    case (ps_reg)
                        swar_pkg::PS_FLAG:
                        begin
                            if (rx_byte == cfg.address_byte)
                                ps_next = swar_pkg::PS_ADDR;
                            else if (rx_byte != cfg.flag_byte)
                                ps_next = swar_pkg::PS_START;
                        end
                        swar_pkg::PS_ADDR:
                        begin
                            if (rx_byte == cfg.flag_byte)
                                ps_next = swar_pkg::PS_FLAG;
                            else if (is_ctrl)
                            begin
                                ctrl_next = rx_byte;
                                ps_next   = swar_pkg::PS_CTRL;
                            end
                            else
                                ps_next = swar_pkg::PS_START;
                        end
                        swar_pkg::PS_CTRL:
                        begin
                            if (rx_byte == cfg.flag_byte)
                                ps_next = swar_pkg::PS_FLAG;
                            else if (rx_byte == (cfg.address_byte ^ ctrl_reg))
                                ps_next = swar_pkg::PS_BCC;
                            else
                                ps_next = swar_pkg::PS_START;
                        end
                        swar_pkg::PS_BCC:
                        begin
                            ps_next    = swar_pkg::PS_START;
                            frame_done = (rx_byte == cfg.flag_byte);
                        end
                        default:
                        begin
                            ps_next = (rx_byte == cfg.flag_byte) ? swar_pkg::PS_FLAG
                                                                 : swar_pkg::PS_START;
                        end
                    endcase

                    if (frame_done)
                    begin
                        if (ctrl_reg == swar_pkg::rej_code(seq_reg))
                        begin
                            cnt_next = '0;
                            act      = swar_pkg::ACT_SEND;
                        end
                        else if (ctrl_reg == swar_pkg::rr_code(!seq_reg))
                        begin
                            seq_next    = !seq_reg;
                            active_next = 1'b0;
                            act         = swar_pkg::ACT_ACK;
                        end
                        else
                        begin
                            active_next = 1'b0;
                            act         = swar_pkg::ACT_FAIL;
                        end
                    end
                end
            end
            default:
            begin
                act = swar_pkg::ACT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg     <= swar_pkg::PS_START;
            ctrl_reg   <= '0;
            seq_reg    <= 1'b0;
            cnt_reg    <= '0;
            active_reg <= 1'b0;
        end
        else if (fire)
        begin
            ps_reg     <= ps_next;
            ctrl_reg   <= ctrl_next;
            seq_reg    <= seq_next;
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
        end
    end

    assign result.action  = act;
    assign result.seq_bit = seq_next;

    `SWAR_ASSERT_NEXT(a_start_arms, clk, rst_n, fire && (cmd == swar_pkg::CMD_START), active_reg && (ps_reg == swar_pkg::PS_START) && (cnt_reg == 9'd0))
    `SWAR_ASSERT_NEXT(a_ack_toggles, clk, rst_n, fire && (act == swar_pkg::ACT_ACK), !active_reg && (seq_reg != $past(seq_reg)))
    `SWAR_ASSERT_NEXT(a_fail_disarms, clk, rst_n, fire && (act == swar_pkg::ACT_FAIL), !active_reg && (seq_reg == $past(seq_reg)))
    `SWAR_ASSERT_NOW(a_idle_quiet, clk, rst_n, !active_reg && (cmd != swar_pkg::CMD_START), act == swar_pkg::ACT_NONE)

endmodule

### hw/rtl/stop_and_wait_ack_receiver.sv
// Path: an accepted input transfer enters the input register and then the result
// register, which drives out_valid. Throughput: one item per cycle unless out_stall
// holds the result register; each of the two registers holds one item, and the
// protocol state updates as an item leaves the input register.
// Reset (rst_n low, asynchronous): pipeline empty, parser waiting, sequence 0,
// count 0, disarmed; registers back to flag 0x7E, address 0x03, limit 3.
// ----------------------------------------------------------------------------
// stop_and_wait_ack_receiver
// Sender side of a stop-and-wait link: parses RR/REJ responses and timeouts.
// ----------------------------------------------------------------------------
`include "stop_and_wait_ack_receiver_macros.svh"

module stop_and_wait_ack_receiver
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swar_pkg::ADDR_W-1:0] paddr,
    input  logic [swar_pkg::DATA_W-1:0] pwdata,
    output logic [swar_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  cmd,
    input  logic [7:0]                  rx_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  action,
    output logic                        seq_bit
);

    swar_pkg::cfg_t    cfg;
    swar_pkg::result_t result;

    logic       s1_valid_reg;
    logic [1:0] s1_cmd_reg;
    logic [7:0] s1_byte_reg;
    logic       out_valid_reg;
    logic [1:0] out_action_reg;
    logic       out_seq_reg;
    logic       advance;
    logic       in_take;

    swar_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // item moves from the input register into the result register
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    swar_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (advance),
        .cmd     (s1_cmd_reg),
        .rx_byte (s1_byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg  <= cmd;
            s1_byte_reg <= rx_byte;
        end
        if (advance)
        begin
            out_action_reg <= result.action;
            out_seq_reg    <= result.seq_bit;
        end
    end

    assign out_valid = out_valid_reg;
    assign action    = out_action_reg;
    assign seq_bit   = out_seq_reg;

    `SWAR_ASSERT_NEXT(a_take_loads, clk, rst_n, in_take, s1_valid_reg)
    `SWAR_ASSERT_NEXT(a_advance_shows, clk, rst_n, advance, out_valid_reg)
    `SWAR_ASSERT_NOW(a_no_stall_when_empty, clk, rst_n, !s1_valid_reg, !in_stall)

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stop-and-wait acknowledgment receiver: drives
// start, expiry and received-byte transfers with random gaps and stalls,
// predicts every action and sequence bit, and checks results in order.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int unsigned GAP_MAX     = 16;
    localparam int unsigned PHASES      = 8;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
    } link_item_t;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [swar_pkg::ADDR_W-1:0] paddr     = '0;
    logic [swar_pkg::DATA_W-1:0] pwdata    = '0;
    logic [swar_pkg::DATA_W-1:0] prdata;
    logic                        pready;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    logic [1:0]                  cmd       = swar_pkg::CMD_BYTE;
    logic [7:0]                  rx_byte   = 8'h00;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [1:0]                  action;
    logic                        seq_bit;

    stop_and_wait_ack_receiver u_dut (.*);

    // predictor copy of the settings and protocol state
    logic [7:0]             flag_cfg  = swar_pkg::FLAG_RESET;
    logic [7:0]             addr_cfg  = swar_pkg::ADDRESS_RESET;
    logic [7:0]             limit_cfg = swar_pkg::LIMIT_RESET;
    swar_pkg::parse_state_t pstate    = swar_pkg::PS_START;
    logic [7:0]             ctl_seen  = 8'h00;
    logic                   seq_now   = 1'b0;
    logic [8:0]             expiries  = 9'd0;
    logic                   armed     = 1'b0;

    link_item_t         item_q[$];
    swar_pkg::result_t  want_q[$];
    swar_pkg::result_t  want;
    int unsigned queued     = 0;
    int unsigned accepted   = 0;
    int unsigned fail_count = 0;

    bit          in_taken  = 1'b0;
    bit          in_busy   = 1'b1;
    int unsigned in_gap    = 0;
    bit          out_taken = 1'b0;
    bit          out_busy  = 1'b0;
    int unsigned out_hold  = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Next action and sequence bit for one transfer; advances the predictor state.
    function automatic swar_pkg::result_t arq_response(input logic [1:0] c,
                                                       input logic [7:0] b);
        swar_pkg::result_t r;
        logic              closed;
        logic [7:0]        rr_next;
        logic [7:0]        rej_cur;
        closed = 1'b0;
        r.action = swar_pkg::ACT_NONE;
        if (c == swar_pkg::CMD_START)
        begin
            armed = 1'b1;
            expiries = 9'd0;
            pstate = swar_pkg::PS_START;
            r.action = swar_pkg::ACT_SEND;
        end
        else if (c == swar_pkg::CMD_EXPIRY && armed)
        begin
            expiries = expiries + 9'd1;
            if (expiries > {1'b0, limit_cfg})
            begin
                armed = 1'b0;
                pstate = swar_pkg::PS_START;
                r.action = swar_pkg::ACT_FAIL;
            end
            else
                r.action = swar_pkg::ACT_SEND;
        end
        else if (c == swar_pkg::CMD_BYTE && armed)
        begin
            case (pstate)
                swar_pkg::PS_FLAG:
                    if (b == addr_cfg)
                        pstate = swar_pkg::PS_ADDR;
                    else if (b != flag_cfg)
                        pstate = swar_pkg::PS_START;
                swar_pkg::PS_ADDR:
                    if (b == flag_cfg)
                        pstate = swar_pkg::PS_FLAG;
                    else if ((b & 8'h7B) == swar_pkg::REJ_BASE)
                    begin
                        // 0x01, 0x05, 0x81, 0x85: RR or REJ of either number
                        ctl_seen = b;
                        pstate = swar_pkg::PS_CTRL;
                    end
                    else
                        pstate = swar_pkg::PS_START;
                swar_pkg::PS_CTRL:
                    if (b == flag_cfg)
                        pstate = swar_pkg::PS_FLAG;
                    else if (b == (addr_cfg ^ ctl_seen))
                        pstate = swar_pkg::PS_BCC;
                    else
                        pstate = swar_pkg::PS_START;
                swar_pkg::PS_BCC:
                begin
                    pstate = swar_pkg::PS_START;
                    closed = (b == flag_cfg);
                end
                default:
                    pstate = (b == flag_cfg) ? swar_pkg::PS_FLAG : swar_pkg::PS_START;
            endcase
            if (closed)
            begin
                rr_next = swar_pkg::RR_BASE | {~seq_now, 7'd0};
                rej_cur = swar_pkg::REJ_BASE | {seq_now, 7'd0};
                if (ctl_seen == rej_cur)
                begin
                    expiries = 9'd0;
                    r.action = swar_pkg::ACT_SEND;
                end
                else if (ctl_seen == rr_next)
                begin
                    seq_now = ~seq_now;
                    armed = 1'b0;
                    r.action = swar_pkg::ACT_ACK;
                end
                else
                begin
                    armed = 1'b0;
                    r.action = swar_pkg::ACT_FAIL;
                end
            end
        end
        r.seq_bit = seq_now;
        return r;
    endfunction

    // ---------------- link driver ----------------
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            want_q.push_back(arq_response(cmd, rx_byte));
            accepted++;
            in_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin : drive_link
        link_item_t nxt;
        logic       valid_nxt;
        if (rst_n)
        begin
            valid_nxt = in_valid;
            if (in_taken)
            begin
                in_taken = 1'b0;
                valid_nxt = 1'b0;
                if ($urandom_range(0, 63) == 0)
                    in_busy = !in_busy;
                in_gap = in_busy ? $urandom_range(0, GAP_MAX) : 0;
            end
            if (!valid_nxt)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (item_q.size() > 0)
                begin
                    nxt = item_q.pop_front();
                    cmd <= nxt.cmd;
                    rx_byte <= nxt.rx_byte;
                    valid_nxt = 1'b1;
                end
            end
            in_valid <= valid_nxt;
        end
    end

    // ---------------- result monitor ----------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            out_taken = 1'b1;
            if (want_q.size() == 0)
            begin
                $error("result transfer with nothing expected: action %0d seq_bit %0d",
                       action, seq_bit);
                fail_count++;
            end
            else
            begin
                want = want_q.pop_front();
                if (action !== want.action)
                begin
                    $error("action: expected %0d, got %0d", want.action, action);
                    fail_count++;
                end
                if (seq_bit !== want.seq_bit)
                begin
                    $error("seq_bit: expected %0d, got %0d", want.seq_bit, seq_bit);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (out_taken)
        begin
            out_taken = 1'b0;
            if ($urandom_range(0, 63) == 0)
                out_busy = !out_busy;
            out_hold = out_busy ? $urandom_range(0, GAP_MAX) : 0;
        end
        if (out_hold > 0)
        begin
            out_stall <= 1'b1;
            out_hold--;
        end
        else
            out_stall <= 1'b0;
    end

    // ---------------- stimulus ----------------
    task automatic push_item(input logic [1:0] c, input logic [7:0] b);
        item_q.push_back('{cmd: c, rx_byte: b});
        queued++;
    endtask

    function automatic logic [7:0] any_ctl();
        return ($urandom_range(0, 1) ? swar_pkg::RR_BASE : swar_pkg::REJ_BASE)
               | {1'($urandom_range(0, 1)), 7'd0};
    endfunction

    // Supervisory frame with the current flag and address; a broken one gets a
    // corrupted byte or is cut short.
    task automatic push_frame(input logic [7:0] ctl, input bit broken);
        logic [7:0]  fb [5];
        int unsigned n;
        fb[0] = flag_cfg;
        fb[1] = addr_cfg;
        fb[2] = ctl;
        fb[3] = addr_cfg ^ ctl;
        fb[4] = flag_cfg;
        n = 5;
        if (broken)
        begin
            if ($urandom_range(0, 1))
                fb[$urandom_range(0, 4)] = 8'($urandom_range(0, 255));
            else
                n = $urandom_range(1, 4);
        end
        if ($urandom_range(0, 3) == 0)
            push_item(swar_pkg::CMD_BYTE, flag_cfg);
        for (int i = 0; i < n; i++)
            push_item(swar_pkg::CMD_BYTE, fb[i]);
    endtask

    task automatic random_traffic(input int unsigned count);
        int unsigned stop_at;
        int unsigned steps;
        stop_at = queued + count;
        while (queued < stop_at)
        begin
            if ($urandom_range(0, 15) == 0)
                push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            else
            begin
                push_item(swar_pkg::CMD_START, 8'($urandom_range(0, 255)));
                steps = $urandom_range(1, 5);
                repeat (steps)
                begin
                    case ($urandom_range(0, 9))
                        0, 1: push_item(swar_pkg::CMD_EXPIRY, 8'($urandom_range(0, 255)));
                        2: push_item(swar_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
                        3: push_frame(any_ctl(), 1'b1);
                        default: push_frame(any_ctl(), 1'b0);
                    endcase
                end
            end
        end
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            swar_pkg::REG_FLAG:    flag_cfg = val;
            swar_pkg::REG_ADDRESS: addr_cfg = val;
            swar_pkg::REG_LIMIT:   limit_cfg = val;
            default:               ;
        endcase
    endtask

    task automatic apply_settings(input logic [7:0] f, input logic [7:0] a,
                                  input logic [7:0] l);
        reg_write(swar_pkg::REG_FLAG, f);
        reg_write(swar_pkg::REG_ADDRESS, a);
        reg_write(swar_pkg::REG_LIMIT, l);
    endtask

    // sender holds off until every result is back, then a short pause
    task automatic settle();
        while (accepted < queued || want_q.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ignored while disarmed, reserved command
        push_item(swar_pkg::CMD_BYTE, swar_pkg::FLAG_RESET);
        push_item(swar_pkg::CMD_EXPIRY, 8'h00);
        push_item(CMD_RESERVED, 8'hFF);
        // expiries up to and past the limit
        push_item(swar_pkg::CMD_START, 8'h00);
        repeat (4) push_item(swar_pkg::CMD_EXPIRY, 8'h00);
        // REJ of the current number, restart while armed, then RR of the next
        push_item(swar_pkg::CMD_START, 8'h00);
        push_frame(swar_pkg::REJ_BASE, 1'b0);
        push_item(swar_pkg::CMD_START, 8'h00);
        push_frame(swar_pkg::RR_BASE | {1'b1, 7'd0}, 1'b0);
        random_traffic(160);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: apply_settings(8'h00, 8'hFF, 8'h00);
                1: apply_settings(8'hFF, 8'h00, 8'hFF);
                // flag equal to the address and to RR(0)
                2: apply_settings(swar_pkg::RR_BASE, swar_pkg::RR_BASE, 8'h01);
                // flag equal to REJ(1), address equal to RR(1)
                3: apply_settings(swar_pkg::REJ_BASE | {1'b1, 7'd0},
                                  swar_pkg::RR_BASE | {1'b1, 7'd0}, 8'h02);
                default: apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                        8'($urandom_range(0, 5)));
            endcase
            if (limit_cfg == 8'hFF)
            begin
                // count runs into its ninth bit before failing
                push_item(swar_pkg::CMD_START, 8'h00);
                repeat (257) push_item(swar_pkg::CMD_EXPIRY, 8'h00);
            end
            random_traffic(160);
            settle();
        end

        if (fail_count == 0 && want_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
